// File: rtl/ils_pkg.sv
`timescale 1ns / 1ps
package ils_pkg;

   // default list capacity
   localparam int CAPACITY_DEF = 64;

   // positions and counts are compared at this width (covers capacity 256)
   localparam int POS_EXT_W = 9;

   localparam int DATA_W = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]               opcode;
      logic [7:0]               position;
      logic signed [DATA_W-1:0] item_value;
   } ils_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [6:0]               entry_count;
      logic [1:0]               status;
   } ils_rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic                     rd;
      logic [POS_EXT_W-1:0]     at;
      logic signed [DATA_W-1:0] value;
   } ils_ctrl_type;

endpackage

// File: rtl/ils_cell.sv
`timescale 1ns / 1ps
module ils_cell
   import ils_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  logic                     clock,
   input  ils_ctrl_type             ctrl,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] right_value,
   output logic signed [DATA_W-1:0] cell_value,
   output logic signed [DATA_W-1:0] hit_value
);

   localparam logic [POS_EXT_W-1:0] MY_IDX = POS_EXT_W'(CELL_IDX);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.ins) begin
         if (MY_IDX == ctrl.at) begin
            value_in = ctrl.value;
         end else if (MY_IDX > ctrl.at) begin
            value_in = left_value;
         end
      end else if (ctrl.rem) begin
         // close the gap from the right
         if (MY_IDX >= ctrl.at) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;
   assign hit_value  = (ctrl.rd && (MY_IDX == ctrl.at)) ? value_ff : '0;

endmodule

// File: rtl/indexed_list_store_unit.sv
`timescale 1ns / 1ps
// result: registered, valid in the cycle after its request transfer
// throughput: one operation per cycle while the result is not stalled; every cell shifts or holds in parallel
// the next request is taken while a result waits, unless the result is stalled
// reset: synchronous active high, clears count and result valid
// entry storage is not reset; only entries below count are ever read
module indexed_list_store_unit
   import ils_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ils_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ils_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [POS_EXT_W-1:0] CAP_EXT = POS_EXT_W'(CAPACITY);

   // entry count
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   ils_rsp_type rsp_data_ff;
   ils_rsp_type rsp_data_in;

   logic                     accept;
   logic [POS_EXT_W-1:0]     count_ext;
   logic [POS_EXT_W-1:0]     count_next_ext;
   logic [POS_EXT_W-1:0]     pos_ext;
   logic                     is_full;
   logic                     pos_past_end;
   logic                     ins_ok;
   logic                     rem_ok;
   logic                     rd_ok;
   ils_ctrl_type             ctrl;
   logic signed [DATA_W-1:0] read_word;

   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] hit_value  [CAPACITY];

   // request transfer whenever the result slot is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign count_ext    = POS_EXT_W'(count_ff);
   assign pos_ext      = POS_EXT_W'(req_data.position);
   assign is_full      = count_ext >= CAP_EXT;
   assign pos_past_end = pos_ext >= count_ext;

   assign ins_ok = (req_data.opcode == OP_INSERT) && !is_full;
   assign rem_ok = (req_data.opcode == OP_REMOVE) && (count_ff != '0) && !pos_past_end;
   assign rd_ok  = (req_data.opcode == OP_READ) && !pos_past_end;

   // control broadcast along the chain
   always_comb begin
      ctrl.ins   = accept && ins_ok;
      ctrl.rem   = accept && rem_ok;
      ctrl.rd    = rd_ok;
      // insert past the end appends at count
      ctrl.at    = (req_data.opcode == OP_INSERT && pos_past_end) ? count_ext : pos_ext;
      ctrl.value = req_data.item_value;
   end

   // cell chain: cells past the insert slot take their left neighbor, cells from the remove slot their right
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      logic signed [DATA_W-1:0] right_v;

      if (g == 0) begin : g_first
         assign left_v = req_data.item_value;
      end else begin : g_mid_l
         assign left_v = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[g];
      end else begin : g_mid_r
         assign right_v = cell_value[g+1];
      end

      ils_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .cell_value  (cell_value[g]),
         .hit_value   (hit_value[g])
      );
   end

   // at most one cell drives a nonzero hit value
   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | hit_value[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_next_ext = POS_EXT_W'(count_in);

   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_valid_in            = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.read_value  = read_word;
         rsp_data_in.entry_count = count_next_ext[6:0];
         rsp_data_in.status      = ST_OK;
         if (req_data.opcode == OP_INSERT && is_full) begin
            rsp_data_in.status = ST_FULL;
         end else if (req_data.opcode == OP_REMOVE && count_ff != '0 && pos_past_end) begin
            rsp_data_in.status = ST_RANGE;
         end else if (req_data.opcode == OP_READ && pos_past_end) begin
            rsp_data_in.status = ST_RANGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      POS_EXT_W'(count_ff) <= CAP_EXT)
      else $error("entry count above capacity");

   // every request transfer produces a result next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("result missing after request transfer");

   // a successful insert grows the list by one
   a_ins_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && ins_ok) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow count");

   // full status only when the list is at capacity
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == ST_FULL) |-> (POS_EXT_W'(count_ff) == CAP_EXT))
      else $error("full status with room left");

endmodule
